### sv/fully_assoc_cache_fifo_core_assert.svh
// assertion macros used by the back end of the cache tag store
`ifndef FULLY_ASSOC_CACHE_FIFO_CORE_ASSERT_SVH
`define FULLY_ASSOC_CACHE_FIFO_CORE_ASSERT_SVH

// checked at every clock edge outside reset
`define FAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define FAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/fac_pkg.sv
// shared types, constants and register codes of the cache tag store
package fac_pkg;

  localparam int LINES      = 16;
  localparam int LINE_BITS  = $clog2(LINES);
  localparam int LCNT_BITS  = $clog2(LINES + 1);
  localparam int ADDR_BITS  = 16;
  localparam int DCNT_BITS  = $clog2(ADDR_BITS);
  localparam int WORD_BITS  = 6;
  localparam int BLK_BITS   = 7;
  localparam int BLK_MAX    = 64;
  localparam int CNT_BITS   = 16;
  localparam int DATA_BITS  = 32;
  localparam int PADDR_BITS = 3;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  // register index codes (byte address bit 2)
  localparam logic REG_LINES = 1'b0;
  localparam logic REG_BLOCK = 1'b1;

  localparam logic [LCNT_BITS-1:0] LINES_RST = LCNT_BITS'(LINES);
  localparam logic [BLK_BITS-1:0]  BLOCK_RST = BLK_BITS'(4);

  typedef enum logic [1:0] {
    ACT_HIT     = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_REPLACE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  // clamped configuration seen by the datapath
  typedef struct packed {
    logic [LCNT_BITS-1:0] lines;
    logic [BLK_BITS-1:0]  block;
  } cfg_t;

  // split address handed from front to back
  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic [WORD_BITS-1:0] word;
  } split_t;

endpackage

### sv/fac_cfg.sv
// configuration registers behind the apb-style port, with range clamping
module fac_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fac_pkg::PADDR_BITS-1:0] paddr,
  input  logic [fac_pkg::DATA_BITS-1:0]  pwdata,
  output logic [fac_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output fac_pkg::cfg_t                  cfg
);
  import fac_pkg::*;

  logic [LCNT_BITS-1:0] lines_r;
  logic [BLK_BITS-1:0]  block_r;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r <= LINES_RST;
      block_r <= BLOCK_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LINES: lines_r <= pwdata[LCNT_BITS-1:0];
        REG_BLOCK: block_r <= pwdata[BLK_BITS-1:0];
        default:   lines_r <= lines_r;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_LINES: prdata = DATA_BITS'(lines_r);
      REG_BLOCK: prdata = DATA_BITS'(block_r);
      default:   prdata = '0;
    endcase
  end

  // zero acts as one, anything above the limit acts as the limit
  always_comb begin
    if (lines_r == '0)
      cfg.lines = LCNT_BITS'(1);
    else if (lines_r > LCNT_BITS'(LINES))
      cfg.lines = LCNT_BITS'(LINES);
    else
      cfg.lines = lines_r;
    if (block_r == '0)
      cfg.block = BLK_BITS'(1);
    else if (block_r > BLK_BITS'(BLK_MAX))
      cfg.block = BLK_BITS'(BLK_MAX);
    else
      cfg.block = block_r;
  end

endmodule

### sv/fac_front.sv
// front end: accepts an address and splits it into tag and word, one bit a cycle
module fac_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [fac_pkg::ADDR_BITS-1:0] in_address,
  output logic                          in_full,
  input  logic [fac_pkg::BLK_BITS-1:0]  block,
  output logic                          q_push,
  output fac_pkg::split_t               q_data,
  input  logic                          q_full
);
  import fac_pkg::*;

  front_state_t          state_r, state_nxt;
  logic [DCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0]  dvd_r, dvd_nxt;
  logic [WORD_BITS-1:0]  rem_r, rem_nxt;
  logic [BLK_BITS-1:0]   div_r, div_nxt;
  logic [BLK_BITS-1:0]   rem_shift;
  logic                  q_bit;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_r, dvd_r[ADDR_BITS-1]};
  assign q_bit     = (rem_shift >= div_r);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    in_full   = 1'b1;
    q_push    = 1'b0;
    case (state_r)
      FS_IDLE: begin
        in_full = 1'b0;
        if (in_push) begin
          dvd_nxt   = in_address;
          rem_nxt   = '0;
          div_nxt   = block;
          cnt_nxt   = DCNT_BITS'(ADDR_BITS - 1);
          state_nxt = FS_DIV;
        end
      end
      FS_DIV: begin
        dvd_nxt = {dvd_r[ADDR_BITS-2:0], q_bit};
        rem_nxt = q_bit ? WORD_BITS'(rem_shift - div_r) : rem_shift[WORD_BITS-1:0];
        cnt_nxt = cnt_r - DCNT_BITS'(1);
        if (cnt_r == '0)
          state_nxt = FS_PUSH;
      end
      FS_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  assign q_data.tag  = dvd_r;
  assign q_data.word = rem_r;

endmodule

### sv/fac_queue.sv
// two-entry queue between the front and back ends
module fac_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fac_pkg::split_t push_data,
  output logic            full,
  input  logic            pop,
  output fac_pkg::split_t pop_data,
  output logic            valid
);
  import fac_pkg::*;

  split_t       mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;
  assign pop_data = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push)
        wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)
        rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)
        count_r <= count_r + 2'd1;
      else if (do_pop && !do_push)
        count_r <= count_r - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### sv/fac_back.sv
// back end: tag lookup, fifo replacement, counters and the result register
module fac_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fac_pkg::LCNT_BITS-1:0] lines,
  input  logic                          q_valid,
  input  fac_pkg::split_t               q_data,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [fac_pkg::ADDR_BITS-1:0] out_tag,
  output logic [fac_pkg::WORD_BITS-1:0] out_word,
  output logic                          out_hit,
  output logic [1:0]                    out_action,
  output logic [fac_pkg::LINE_BITS-1:0] out_line,
  output logic [fac_pkg::CNT_BITS-1:0]  out_hit_total,
  output logic [fac_pkg::CNT_BITS-1:0]  out_miss_total
);
  import fac_pkg::*;
  `include "fully_assoc_cache_fifo_core_assert.svh"

  logic [ADDR_BITS-1:0] tags_r [LINES];
  logic [LINES-1:0]     valid_r;
  logic [LCNT_BITS-1:0] fill_r, fill_nxt;
  logic [LINE_BITS-1:0] victim_r, victim_nxt;
  logic [CNT_BITS-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_BITS-1:0]  miss_cnt_r, miss_cnt_nxt;

  logic                 res_valid_r;
  logic [ADDR_BITS-1:0] res_tag_r;
  logic [WORD_BITS-1:0] res_word_r;
  logic                 res_hit_r;
  action_t              res_act_r;
  logic [LINE_BITS-1:0] res_line_r;

  logic                 take;
  logic                 hit;
  logic [LINE_BITS-1:0] hit_line;
  logic [LINE_BITS-1:0] vp_eff;
  logic [LCNT_BITS-1:0] vp_inc;
  logic                 insert;
  logic [LINE_BITS-1:0] sel_line;
  action_t              act;

  // take the next split address when the result slot frees up
  assign take  = q_valid & (~res_valid_r | out_pop);
  assign q_pop = take;

  // parallel compare, lowest matching line wins
  always_comb begin
    hit      = 1'b0;
    hit_line = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid_r[i] && (tags_r[i] == q_data.tag) && (LCNT_BITS'(i) < lines)) begin
        hit      = 1'b1;
        hit_line = LINE_BITS'(i);
      end
    end
  end

  // victim pointer restarts at zero when out of range, wraps at lines in use
  assign vp_eff = ({1'b0, victim_r} >= lines) ? '0 : victim_r;
  assign vp_inc = {1'b0, vp_eff} + LCNT_BITS'(1);
  assign insert = (fill_r < lines);

  // replacement decision and state update
  always_comb begin
    fill_nxt     = fill_r;
    victim_nxt   = victim_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    sel_line     = hit_line;
    act          = ACT_HIT;
    if (hit) begin
      if (hit_cnt_r != CNT_MAX)
        hit_cnt_nxt = hit_cnt_r + CNT_BITS'(1);
    end else begin
      if (miss_cnt_r != CNT_MAX)
        miss_cnt_nxt = miss_cnt_r + CNT_BITS'(1);
      if (insert) begin
        sel_line = fill_r[LINE_BITS-1:0];
        fill_nxt = fill_r + LCNT_BITS'(1);
        act      = ACT_INSERT;
      end else begin
        sel_line   = vp_eff;
        victim_nxt = (vp_inc == lines) ? '0 : vp_inc[LINE_BITS-1:0];
        act        = ACT_REPLACE;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fill_r      <= '0;
      victim_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        fill_r     <= fill_nxt;
        victim_r   <= victim_nxt;
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
        if (!hit)
          valid_r[sel_line] <= 1'b1;
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // tag store and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (!hit)
        tags_r[sel_line] <= q_data.tag;
      res_tag_r  <= q_data.tag;
      res_word_r <= q_data.word;
      res_hit_r  <= hit;
      res_act_r  <= act;
      res_line_r <= sel_line;
    end
  end

  assign out_empty      = ~res_valid_r;
  assign out_tag        = res_tag_r;
  assign out_word       = res_word_r;
  assign out_hit        = res_hit_r;
  assign out_action     = res_act_r;
  assign out_line       = res_line_r;
  assign out_hit_total  = hit_cnt_r;
  assign out_miss_total = miss_cnt_r;

  // checks
  `FAC_ASSERT(a_fill_bound, (fill_r <= LCNT_BITS'(LINES)), "fill count beyond line count")
  `FAC_ASSERT(a_insert_fill, (take && !hit && insert) |=> (fill_r == $past(fill_r) + LCNT_BITS'(1)), "insert did not advance fill count")
  `FAC_ASSERT(a_hit_count, (take && hit && hit_cnt_r != CNT_MAX) |=> (hit_cnt_r == $past(hit_cnt_r) + CNT_BITS'(1)), "hit not counted")
  `FAC_ASSERT(a_miss_keep, (take && hit) |=> ((miss_cnt_r == $past(miss_cnt_r)) && (fill_r == $past(fill_r))), "hit changed miss state")

endmodule

### sv/fully_assoc_cache_fifo_core.sv
// top level of the fully associative cache tag store with fifo replacement
//
// input channel: drive in_address with in_push; a beat is taken at a clock
// edge where in_push is high and in_full is low.
// result channel: while out_empty is low the oldest result sits on the out_
// ports; it is taken at a clock edge where out_pop is high.
// configuration: apb-style writes to lines_in_use (byte 0) and block_words
// (byte 4); write only while no beat is in flight.
// each address is split by a bit-serial restoring divider, one quotient bit
// a cycle; the front end takes a new beat only once the last one has passed
// accept, 16 divide steps and hand-off to the queue.
// the front end hands split addresses to the back end through a two-entry
// queue; the back end does the tag compare and update into a result
// register, so a stalled receiver first fills the queue and then holds the
// front end in its hand-off, with in_full high.
// reset (rst_n low, synchronous) clears all line valid bits, the fill count,
// the victim pointer and both counters, and restores the register defaults.
module fully_assoc_cache_fifo_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [fac_pkg::ADDR_BITS-1:0]  in_address,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [fac_pkg::ADDR_BITS-1:0]  out_tag,
  output logic [fac_pkg::WORD_BITS-1:0]  out_word,
  output logic                           out_hit,
  output logic [1:0]                     out_action,
  output logic [fac_pkg::LINE_BITS-1:0]  out_line,
  output logic [fac_pkg::CNT_BITS-1:0]   out_hit_total,
  output logic [fac_pkg::CNT_BITS-1:0]   out_miss_total,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fac_pkg::PADDR_BITS-1:0] paddr,
  input  logic [fac_pkg::DATA_BITS-1:0]  pwdata,
  output logic [fac_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);
  import fac_pkg::*;

  cfg_t   cfg;
  logic   q_push, q_full, q_pop, q_valid;
  split_t q_in, q_out;

  // configuration registers
  fac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // address split
  fac_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_address (in_address),
    .in_full    (in_full),
    .block      (cfg.block),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  // decoupling queue
  fac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .valid     (q_valid)
  );

  // lookup and replacement
  fac_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .lines          (cfg.lines),
    .q_valid        (q_valid),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_tag        (out_tag),
    .out_word       (out_word),
    .out_hit        (out_hit),
    .out_action     (out_action),
    .out_line       (out_line),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

endmodule

### verif/testbench.sv
// self-checking testbench for the fully associative cache tag store
`timescale 1ns / 1ps

module testbench;
  import fac_pkg::*;

  localparam int QUIET_LIMIT  = 4000;  // cycles with no beat before giving up
  localparam int LONG_HOLD    = 400;   // receiver hold-off to back up the block
  localparam int SETTLE_GAP   = 40;
  localparam int CHUNK_ITEMS  = 117;
  localparam int CHUNKS       = 4;

  // expected outcome of one access
  typedef struct {
    logic [ADDR_BITS-1:0] tag;
    logic [WORD_BITS-1:0] word;
    logic                 hit;
    action_t              action;
    logic [LINE_BITS-1:0] line;
    logic [CNT_BITS-1:0]  hit_total;
    logic [CNT_BITS-1:0]  miss_total;
  } lookup_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [ADDR_BITS-1:0]  in_address = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [ADDR_BITS-1:0]  out_tag;
  logic [WORD_BITS-1:0]  out_word;
  logic                  out_hit;
  logic [1:0]            out_action;
  logic [LINE_BITS-1:0]  out_line;
  logic [CNT_BITS-1:0]   out_hit_total;
  logic [CNT_BITS-1:0]   out_miss_total;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  fully_assoc_cache_fifo_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_address    (in_address),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tag       (out_tag),
    .out_word      (out_word),
    .out_hit       (out_hit),
    .out_action    (out_action),
    .out_line      (out_line),
    .out_hit_total (out_hit_total),
    .out_miss_total(out_miss_total),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // shadow copy of the tag store and its registers
  logic [ADDR_BITS-1:0] line_tag   [LINES];
  logic                 line_live  [LINES] = '{default: 1'b0};
  int unsigned          fill_cnt   = 0;
  int unsigned          victim_ptr = 0;
  logic [CNT_BITS-1:0]  hit_cnt    = '0;
  logic [CNT_BITS-1:0]  miss_cnt   = '0;
  logic [LCNT_BITS-1:0] lines_reg  = LINES_RST;
  logic [BLK_BITS-1:0]  block_reg  = BLOCK_RST;

  // traffic bookkeeping
  logic [ADDR_BITS-1:0] addr_backlog [$];
  lookup_t              lookup_q     [$];
  int                   items_queued = 0;
  int                   results_seen = 0;
  int                   hits_seen    = 0;
  int                   misses_seen  = 0;
  int                   reg_writes   = 0;
  int                   errors       = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  bit                   long_hold_req = 1'b0;
  bit                   long_hold_done = 1'b0;
  int                   hold_left = 0;
  int                   quiet_cycles = 0;

  function automatic int unsigned eff_block();
    if (block_reg == 0) return 1;
    if (block_reg > BLK_MAX) return BLK_MAX;
    return block_reg;
  endfunction

  // tag compare and fifo replacement for one access, updates the shadow store
  function automatic lookup_t cache_lookup(input logic [ADDR_BITS-1:0] addr);
    lookup_t     r;
    int unsigned n;
    int unsigned b;
    int unsigned tg;
    int unsigned ln;
    int unsigned i;
    bit          found;
    n = (lines_reg == 0) ? 1 : ((lines_reg > LINES) ? LINES : lines_reg);
    b = eff_block();
    tg = addr / b;
    found = 1'b0;
    ln = 0;
    for (i = 0; i < n; i++) begin
      if (!found && line_live[i] && line_tag[i] == tg) begin
        found = 1'b1;
        ln = i;
      end
    end
    r.action = ACT_HIT;
    if (found) begin
      if (hit_cnt != CNT_MAX) hit_cnt++;
    end else begin
      if (miss_cnt != CNT_MAX) miss_cnt++;
      if (fill_cnt < n) begin
        // empty lines fill in order
        ln = fill_cnt;
        fill_cnt++;
        r.action = ACT_INSERT;
      end else begin
        // store full: pointer restarts at line 0 if lines were cut below it
        if (victim_ptr >= n) victim_ptr = 0;
        ln = victim_ptr;
        victim_ptr = (victim_ptr + 1) % n;
        r.action = ACT_REPLACE;
      end
      line_tag[ln] = ADDR_BITS'(tg);
      line_live[ln] = 1'b1;
    end
    r.tag = ADDR_BITS'(tg);
    r.word = WORD_BITS'(addr % b);
    r.hit = found;
    r.line = LINE_BITS'(ln);
    r.hit_total = hit_cnt;
    r.miss_total = miss_cnt;
    return r;
  endfunction

  // sender: offers backlog addresses, predicts each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        lookup_q.push_back(cache_lookup(in_address));
      end
      if (!in_push || !in_full) begin
        if (addr_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_push <= 1'b1;
          in_address <= addr_backlog.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: random pop with one long hold-off, checks each result beat
  always @(posedge clk) begin
    lookup_t w;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (out_hit) hits_seen++;
        else misses_seen++;
        if (lookup_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, tag %0d", $time, out_tag);
          errors++;
        end else begin
          w = lookup_q.pop_front();
          check_field("tag", w.tag, out_tag);
          check_field("word", w.word, out_word);
          check_field("hit", w.hit, out_hit);
          check_field("action", int'(w.action), out_action);
          check_field("line", w.line, out_line);
          check_field("hit_total", w.hit_total, out_hit_total);
          check_field("miss_total", w.miss_total, out_miss_total);
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_addr(input logic [ADDR_BITS-1:0] a);
    addr_backlog.push_back(a);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [DATA_BITS-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_LINES) lines_reg = v[LCNT_BITS-1:0];
    else block_reg = v[BLK_BITS-1:0];
    reg_writes++;
  endtask

  // new register setting, only once every pending beat has come back
  task automatic set_config(input int unsigned lines, input int unsigned block);
    wait_drained();
    reg_write(REG_LINES, lines);
    reg_write(REG_BLOCK, block);
  endtask

  initial begin
    logic [ADDR_BITS-1:0] tag_pool [32];
    int                   pool_n;
    int unsigned          b;
    int                   ph;
    int                   ch;
    int                   k;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 85;

    // reset defaults: fills, hits within a block, top address
    push_addr(16'd0);
    push_addr(16'd3);
    push_addr(16'hFFFF);
    push_addr(16'd4);
    push_addr(16'd0);

    // zero codes act as one line and one-word blocks; store counts as full
    set_config(0, 0);
    push_addr(16'hFFFF);
    push_addr(16'hFFFF);
    // tag sits in a valid line beyond the lines in use
    push_addr(16'd1);
    push_addr(16'd2);

    // oversize codes clamp to 16 lines and 64 words; empty lines fill again
    set_config(31, 127);
    push_addr(16'd63);
    push_addr(16'd64);
    push_addr(16'hFFFF);
    push_addr(16'd65472);

    // odd block size, two lines, victim pointer wraps
    set_config(2, 3);
    push_addr(16'd100);
    push_addr(16'd200);
    push_addr(16'd300);
    push_addr(16'd101);
    push_addr(16'd400);
    push_addr(16'd302);
    push_addr(16'd0);

    // random phases: idle mix changes, then several settings per phase
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : ((ph == 1) ? 85 : 0);
      recv_idle_pct = (ph == 0) ? 85 : ((ph == 1) ? 38 : 0);
      for (ch = 0; ch < CHUNKS; ch++) begin
        case ($urandom_range(0, 5))
          0: k = 0;
          1: k = 1;
          2: k = 16;
          3: k = $urandom_range(17, 31);
          default: k = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 5))
          0: b = 0;
          1: b = 1;
          2: b = 64;
          3: b = $urandom_range(65, 127);
          4: b = 1 << $urandom_range(0, 6);
          default: b = $urandom_range(1, 64);
        endcase
        set_config(k, b);
        // back the block up once while the sender keeps offering
        if (ph == 2 && ch == 1) long_hold_req = 1'b1;
        b = eff_block();
        pool_n = $urandom_range(1, 24);
        for (k = 0; k < pool_n; k++)
          tag_pool[k] = ADDR_BITS'($urandom_range(0, 65535 / b - 1));
        for (k = 0; k < CHUNK_ITEMS; k++) begin
          if ($urandom_range(99) < 25) push_addr(ADDR_BITS'($urandom_range(0, 65535)));
          else push_addr(ADDR_BITS'(tag_pool[$urandom_range(0, pool_n - 1)] * b
                                    + $urandom_range(0, b - 1)));
        end
      end
    end

    // the test waits for everything to return before the final check
    wait_drained();
    repeat (SETTLE_GAP) @(posedge clk);

    if (lookup_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, lookup_q.size());
      errors += lookup_q.size();
    end
    $display("run covered %0d accesses (%0d hits, %0d misses) across %0d register writes,",
             results_seen, hits_seen, misses_seen, reg_writes);
    $display("clamped line and block codes, refills after resizing and a full-input hold-off");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
